>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the hashed identifier index RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

>>> hw/rtl/hidlp_pkg.sv
// Types, codes and constants of the hashed identifier index.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hidlp_pkg;

   localparam int TABLE_SLOTS   = 1024;
   localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
   localparam int ID_BITS       = 32;
   localparam int ENTRY_BITS    = 10;
   localparam int OP_BITS       = 2;
   localparam int OUTCOME_BITS  = 3;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 16;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SLOT_BITS-1:0]  SLOT_MASK         = SLOT_BITS'(TABLE_SLOTS - 1);
   localparam logic [ENTRY_BITS-1:0] MAX_ENTRIES_RESET = ENTRY_BITS'(512);

   localparam logic [63:0] MIX_C1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2  = 64'h94d049bb133111eb;
   localparam int          SHIFT_A = 30;
   localparam int          SHIFT_B = 27;
   localparam int          SHIFT_C = 31;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNDEF  = 2'd3
   } op_type;

   typedef enum logic [OUTCOME_BITS-1:0] {
      OUT_HIT      = 3'd0,
      OUT_INSERTED = 3'd1,
      OUT_MISS     = 3'd2,
      OUT_REJECTED = 3'd3,
      OUT_CLEARED  = 3'd4
   } outcome_type;

   typedef struct packed {
      op_type               op;
      logic [ID_BITS-1:0]   key;
      logic [SLOT_BITS-1:0] home;
   } qitem_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    key;
      logic [ENTRY_BITS-1:0] entry;
   } slot_type;

   typedef enum logic [3:0] {
      F_IDLE,
      F_MUL1,
      F_MUL2,
      F_MIX,
      F_MUL3,
      F_MUL4,
      F_MUL5,
      F_FOLD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_SWEEP,
      B_IDLE,
      B_READ,
      B_CHECK,
      B_EMIT
   } back_state_type;

endpackage

>>> hw/rtl/hidlp_front.sv
// Front end: takes request transfers and works out the home slot with the
// 64-bit mixer on one shared 32x32 multiplier. Depends on hidlp_pkg.
`timescale 1ns / 1ps

module hidlp_front
   import hidlp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [31:0] identifier
   input  logic [OP_BITS-1:0]       req_tuser,  // [1:0] operation
   input  logic                     accept_hold,
   output logic                     push_valid,
   input  logic                     push_ready,
   output qitem_type                push_item
);

   front_state_type      state_ff, state_in;
   op_type               op_ff, op_in;
   logic [ID_BITS-1:0]   key_ff, key_in;
   logic [63:0]          v_ff, v_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          prod_ff, prod_in;
   logic [SLOT_BITS-1:0] home_ff, home_in;
   logic [31:0]          mul_a, mul_b;
   logic [63:0]          mul_prod;
   logic [63:0]          key_wide, mix2, mix4;

   assign mul_prod = mul_a * mul_b;
   assign key_wide = 64'(req_tdata[ID_BITS-1:0]);
   assign mix2     = acc_ff + {prod_ff[31:0], 32'd0};
   assign mix4     = acc_ff + {prod_ff[31:0], 32'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      home_ff <= home_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      v_in       = v_ff;
      acc_in     = acc_ff;
      home_in    = home_ff;
      mul_a      = v_ff[31:0];
      mul_b      = MIX_C1[31:0];
      prod_in    = prod_ff;
      req_tready = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_tready = !accept_hold;
            if (req_tvalid && !accept_hold) begin
               op_in   = op_type'(req_tuser);
               key_in  = req_tdata[ID_BITS-1:0];
               v_in    = key_wide ^ (key_wide >> SHIFT_A);
               home_in = '0;
               if (op_type'(req_tuser) == OP_LOOKUP || op_type'(req_tuser) == OP_INSERT) begin
                  state_in = F_MUL1;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_MUL1: begin
            mul_a    = v_ff[31:0];
            mul_b    = MIX_C1[31:0];
            prod_in  = mul_prod;
            state_in = F_MUL2;
         end
         F_MUL2: begin
            acc_in   = prod_ff;
            mul_a    = v_ff[31:0];
            mul_b    = MIX_C1[63:32];
            prod_in  = mul_prod;
            state_in = F_MIX;
         end
         F_MIX: begin
            v_in     = mix2 ^ (mix2 >> SHIFT_B);
            state_in = F_MUL3;
         end
         F_MUL3: begin
            mul_a    = v_ff[31:0];
            mul_b    = MIX_C2[31:0];
            prod_in  = mul_prod;
            state_in = F_MUL4;
         end
         F_MUL4: begin
            acc_in   = prod_ff;
            mul_a    = v_ff[31:0];
            mul_b    = MIX_C2[63:32];
            prod_in  = mul_prod;
            state_in = F_MUL5;
         end
         F_MUL5: begin
            acc_in   = acc_ff + {prod_ff[31:0], 32'd0};
            mul_a    = v_ff[63:32];
            mul_b    = MIX_C2[31:0];
            prod_in  = mul_prod;
            state_in = F_FOLD;
         end
         F_FOLD: begin
            home_in  = mix4[SLOT_BITS-1:0] ^ mix4[SHIFT_C+SLOT_BITS-1:SHIFT_C];
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_item.op   = op_ff;
   assign push_item.key  = key_ff;
   assign push_item.home = home_ff;

endmodule

>>> hw/rtl/hidlp_queue.sv
// Short queue of classified requests between front and back end.
// Depends on hidlp_pkg.
`timescale 1ns / 1ps

module hidlp_queue
   import hidlp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  qitem_type push_item,
   output logic      pop_valid,
   input  logic      pop_ready,
   output qitem_type pop_item
);

   qitem_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = count_ff != QCOUNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/hidlp_back.sv
// Back end: slot memory, linear probe walk, insert, clearing sweep and
// response register. Depends on hidlp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hidlp_back
   import hidlp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [ENTRY_BITS-1:0]    csr_wr_data,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  qitem_type                pop_item,
   output logic                     init_busy,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // [9:0] entry_number, [15:10] zero
   output logic [OUTCOME_BITS-1:0]  rsp_tuser   // [2:0] outcome
);

   slot_type slot_mem [TABLE_SLOTS];
   slot_type rd_ff;

   back_state_type        state_ff, state_in;
   op_type                op_ff, op_in;
   logic [ID_BITS-1:0]    key_ff, key_in;
   logic [SLOT_BITS-1:0]  pos_ff, pos_in;
   logic [SLOT_BITS-1:0]  probes_ff, probes_in;
   logic [ENTRY_BITS-1:0] cnt_ff, cnt_in;
   logic [ENTRY_BITS-1:0] max_ff, max_in;
   logic                  sweep_reply_ff, sweep_reply_in;
   outcome_type           res_out_ff, res_out_in;
   logic [ENTRY_BITS-1:0] res_entry_ff, res_entry_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   outcome_type           rsp_outcome_ff, rsp_outcome_in;
   logic [ENTRY_BITS-1:0] rsp_entry_ff, rsp_entry_in;
   logic                  mem_we;
   slot_type              mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[pos_ff] <= mem_wdata;
      end
      rd_ff <= slot_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_SWEEP;
         pos_ff         <= '0;
         cnt_ff         <= '0;
         max_ff         <= MAX_ENTRIES_RESET;
         sweep_reply_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         cnt_ff         <= cnt_in;
         max_ff         <= max_in;
         sweep_reply_ff <= sweep_reply_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      probes_ff      <= probes_in;
      res_out_ff     <= res_out_in;
      res_entry_ff   <= res_entry_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_entry_ff   <= rsp_entry_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      pos_in         = pos_ff;
      probes_in      = probes_ff;
      cnt_in         = cnt_ff;
      max_in         = csr_wr_en ? csr_wr_data : max_ff;
      sweep_reply_in = sweep_reply_ff;
      res_out_in     = res_out_ff;
      res_entry_in   = res_entry_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_entry_in   = rsp_entry_ff;
      mem_we         = 1'b0;
      mem_wdata      = '0;
      pop_ready      = 1'b0;
      case (state_ff)
         B_SWEEP: begin
            mem_we = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == SLOT_MASK) begin
               cnt_in = '0;
               if (sweep_reply_ff) begin
                  res_out_in   = OUT_CLEARED;
                  res_entry_in = '0;
                  state_in     = B_EMIT;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               op_in        = pop_item.op;
               key_in       = pop_item.key;
               pos_in       = pop_item.home;
               probes_in    = '0;
               res_entry_in = '0;
               case (pop_item.op)
                  OP_LOOKUP: begin
                     res_out_in = OUT_MISS;
                     state_in   = (pop_item.key == '0) ? B_EMIT : B_READ;
                  end
                  OP_INSERT: begin
                     res_out_in = OUT_REJECTED;
                     state_in   = (pop_item.key == '0) ? B_EMIT : B_READ;
                  end
                  OP_CLEAR: begin
                     pos_in         = '0;
                     sweep_reply_in = 1'b1;
                     state_in       = B_SWEEP;
                  end
                  default: begin
                     res_out_in = OUT_REJECTED;
                     state_in   = B_EMIT;
                  end
               endcase
            end
         end
         B_READ: begin
            state_in = B_CHECK;
         end
         B_CHECK: begin
            if (rd_ff.key == '0) begin
               state_in = B_EMIT;
               if (op_ff == OP_INSERT && cnt_ff < max_ff) begin
                  mem_we          = 1'b1;
                  mem_wdata.key   = key_ff;
                  mem_wdata.entry = cnt_ff + 1'b1;
                  cnt_in          = cnt_ff + 1'b1;
                  res_out_in      = OUT_INSERTED;
                  res_entry_in    = cnt_ff + 1'b1;
               end
            end else if (rd_ff.key == key_ff) begin
               res_out_in   = OUT_HIT;
               res_entry_in = rd_ff.entry;
               state_in     = B_EMIT;
            end else if (probes_ff == SLOT_MASK) begin
               state_in = B_EMIT;
            end else begin
               pos_in    = pos_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               state_in  = B_READ;
            end
         end
         B_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_out_ff;
               rsp_entry_in   = res_entry_ff;
               sweep_reply_in = 1'b0;
               state_in       = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign init_busy  = (state_ff == B_SWEEP) && !sweep_reply_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_entry_ff);
   assign rsp_tuser  = rsp_outcome_ff;

   `ASSERT_CLK(a_insert_within_limit, (mem_we && state_ff == B_CHECK) |-> (cnt_ff < max_ff), "insert beyond entry limit")
   `ASSERT_CLK(a_sweep_resets_count, ($past(state_ff) == B_SWEEP && state_ff != B_SWEEP) |-> (cnt_ff == '0), "count not zero after sweep")
   `ASSERT_NEVER(a_numbered_result, rsp_valid_ff && (rsp_outcome_ff == OUT_HIT || rsp_outcome_ff == OUT_INSERTED) && rsp_entry_ff == '0, "hit or insert without entry number")

endmodule

>>> hw/rtl/hashed_id_index_linear_probe.sv
// Hashed identifier index: maps nonzero identifiers to dense entry numbers.
// Top level; depends on hidlp_pkg, hidlp_front, hidlp_queue and hidlp_back.
//
// Request channel req_*: tuser carries the operation (lookup, insert, clear),
// tdata the identifier. Response channel rsp_*: one transfer per request,
// tuser the outcome, tdata the entry number. csr_wr_en/csr_wr_data set the
// entry limit at any idle moment; reset value 512.
// The front end hashes a lookup or insert on one shared 32x32 multiplier,
// then hands it to a two-deep queue; clear and undefined operations pass
// the front end unhashed. The back end takes an item, does one registered
// read of the single slot memory and one compare per probed slot, and then
// loads the response register; a full walk probes up to 1024 slots. The
// front end takes a new request only after it has pushed the last one.
// A clear sweeps all 1024 slots, one per cycle, and then responds. After
// reset the same sweep runs with req_tready low.
// A stalled response is held in the response register while the front end
// keeps taking requests until the queue fills.
`timescale 1ns / 1ps

module hashed_id_index_linear_probe
   import hidlp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [31:0] identifier
   input  logic [OP_BITS-1:0]       req_tuser,   // [1:0] operation
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [9:0] entry_number, [15:10] zero
   output logic [OUTCOME_BITS-1:0]  rsp_tuser,   // [2:0] outcome
   input  logic                     csr_wr_en,
   input  logic [ENTRY_BITS-1:0]    csr_wr_data
);

   logic      push_valid, push_ready;
   qitem_type push_item;
   logic      pop_valid, pop_ready;
   qitem_type pop_item;
   logic      init_busy;

   hidlp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .accept_hold (init_busy),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   hidlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   hidlp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .init_busy   (init_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

>>> sim/hashed_id_index_linear_probe_tb.sv
// Self-checking bench for the hashed identifier index: lookups, inserts and clears go
// over the request stream, entry limits over the CSR port, and every reply is checked
// in order against a shadow table kept here. Depends on hidlp_pkg and the block RTL.
`timescale 1ns / 1ps

module hashed_id_index_linear_probe_tb;
   import hidlp_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_ITEMS = 1150;
   localparam int CALM_ITEMS   = 150;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      outcome_type           outcome;
      logic [ENTRY_BITS-1:0] entry;
   } index_reply_type;

   // Shadow of the slot table; predicts one reply per accepted request.
   class id_index_shadow_type;
      logic [ID_BITS-1:0]    slot_key [TABLE_SLOTS];
      logic [ENTRY_BITS-1:0] slot_entry [TABLE_SLOTS];
      logic [ENTRY_BITS-1:0] entries_used;
      logic [ENTRY_BITS-1:0] entry_limit;
      index_reply_type       pending_replies [$];
      int                    failures;
      int                    replies_seen;

      function new();
         foreach (slot_key[i]) begin
            slot_key[i]   = '0;
            slot_entry[i] = '0;
         end
         entries_used = '0;
         entry_limit  = MAX_ENTRIES_RESET;
         failures     = 0;
         replies_seen = 0;
      endfunction

      function logic [SLOT_BITS-1:0] home_slot(input logic [ID_BITS-1:0] id);
         logic [63:0] v;
         v = 64'(id);
         v = v ^ (v >> SHIFT_A);
         v = v * MIX_C1;
         v = v ^ (v >> SHIFT_B);
         v = v * MIX_C2;
         v = v ^ (v >> SHIFT_C);
         return v[SLOT_BITS-1:0];
      endfunction

      function bit walk_probe(input logic [ID_BITS-1:0] id, output logic [SLOT_BITS-1:0] where,
                              output bit found_empty);
         logic [SLOT_BITS-1:0] pos;
         pos         = home_slot(id);
         where       = '0;
         found_empty = 0;
         for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (slot_key[pos] == '0) begin
               where       = pos;
               found_empty = 1;
               return 0;
            end
            if (slot_key[pos] == id) begin
               where = pos;
               return 1;
            end
            pos = pos + 1'b1;
         end
         return 0;
      endfunction

      function void note_request(input op_type op, input logic [ID_BITS-1:0] id);
         index_reply_type      want;
         logic [SLOT_BITS-1:0] where;
         bit                   found_empty;
         want.outcome = OUT_REJECTED;
         want.entry   = '0;
         case (op)
            OP_CLEAR: begin
               foreach (slot_key[i]) slot_key[i] = '0;
               entries_used = '0;
               want.outcome = OUT_CLEARED;
            end
            OP_LOOKUP: begin
               want.outcome = OUT_MISS;
               if (id != '0 && walk_probe(id, where, found_empty)) begin
                  want.outcome = OUT_HIT;
                  want.entry   = slot_entry[where];
               end
            end
            OP_INSERT: begin
               if (id != '0) begin
                  if (walk_probe(id, where, found_empty)) begin
                     want.outcome = OUT_HIT;
                     want.entry   = slot_entry[where];
                  end else if (found_empty && entries_used < entry_limit) begin
                     entries_used      = entries_used + 1'b1;
                     slot_key[where]   = id;
                     slot_entry[where] = entries_used;
                     want.outcome      = OUT_INSERTED;
                     want.entry        = entries_used;
                  end
               end
            end
            default: ;
         endcase
         pending_replies = {pending_replies, want};
      endfunction

      function void check_reply(input logic [OUTCOME_BITS-1:0] outcome,
                                input logic [RSP_DATA_BITS-1:0] data);
         index_reply_type want;
         replies_seen++;
         if (pending_replies.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: reply %0d outcome %0d data %0d with no request outstanding",
                        $realtime, replies_seen, outcome, data);
            return;
         end
         want = pending_replies.pop_front();
         if (outcome !== want.outcome || data !== RSP_DATA_BITS'(want.entry)) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: reply %0d outcome %0d entry %0d, expected outcome %0d entry %0d",
                        $realtime, replies_seen, outcome, data, want.outcome, want.entry);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // [31:0] identifier
   logic [OP_BITS-1:0]       req_tuser;   // [1:0] operation
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // [9:0] entry_number, [15:10] zero
   logic [OUTCOME_BITS-1:0]  rsp_tuser;   // [2:0] outcome
   logic                     csr_wr_en;
   logic [ENTRY_BITS-1:0]    csr_wr_data;

   id_index_shadow_type shadow = new();
   logic [ID_BITS-1:0]  known_ids [$];
   bit                  calm = 0;
   int                  random_left = RANDOM_ITEMS;
   int                  cycles = 0;

   hashed_id_index_linear_probe DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("hashed_id_index_linear_probe: mismatch");
         $finish;
      end
   end

   // Check the reply before noting the request taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) shadow.check_reply(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready) shadow.note_request(op_type'(req_tuser), req_tdata);
      end
   end

   initial begin
      int stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_tready = 1'b1;
         end else if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_tready = 1'b0;
            stall      = $urandom_range(0, 18);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic send(input op_type op, input logic [ID_BITS-1:0] id);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = id;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (shadow.pending_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [ENTRY_BITS-1:0] value);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en          = 1'b0;
      shadow.entry_limit = value;
   endtask

   function automatic logic [ID_BITS-1:0] known_or_fresh();
      if (known_ids.size() == 0) return $urandom;
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
   endfunction

   function automatic logic [ID_BITS-1:0] id_homed_at(input logic [SLOT_BITS-1:0] slot);
      logic [ID_BITS-1:0] id;
      do id = $urandom; while (id == '0 || shadow.home_slot(id) != slot);
      return id;
   endfunction

   task automatic run_phase(input logic [ENTRY_BITS-1:0] limit, input int count,
                            input bit fill, input bit with_clears);
      int                 pick;
      op_type             op;
      logic [ID_BITS-1:0] id;
      write_limit(limit);
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (fill) pick = (pick < 4) ? pick + 3 : 25 + (pick * 3) / 4;
         op = OP_LOOKUP;
         id = $urandom;
         if (pick < 3) begin
            op = with_clears ? OP_CLEAR : OP_LOOKUP;
         end else if (pick < 5) begin
            op = OP_UNDEF;
         end else if (pick < 8) begin
            op = pick[0] ? OP_INSERT : OP_LOOKUP;
            id = '0;
         end else if (pick < (fill ? 85 : 40)) begin
            op = OP_INSERT;
         end else if (pick < (fill ? 90 : 55)) begin
            op = OP_INSERT;
            id = known_or_fresh();
         end else if (pick < (fill ? 96 : 80)) begin
            id = known_or_fresh();
         end
         if (op == OP_CLEAR) known_ids.delete();
         else if (op == OP_INSERT && id != '0) known_ids = {known_ids, id};
         if (random_left <= CALM_ITEMS) calm = 1;
         send(op, id);
         random_left--;
      end
   endtask

   initial begin
      logic [ID_BITS-1:0] wrap_id [4];
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_LOOKUP;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      reset       = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_limit(MAX_ENTRIES_RESET);
      send(OP_LOOKUP, '0);
      send(OP_INSERT, '0);
      send(OP_LOOKUP, '1);
      send(OP_INSERT, '1);
      send(OP_INSERT, '1);
      send(OP_LOOKUP, '1);
      send(OP_INSERT, 32'h0000_0001);
      send(OP_LOOKUP, 32'h8000_0000);
      send(OP_UNDEF, '1);
      // chain through the top slot and wrap round to slot zero
      foreach (wrap_id[i]) wrap_id[i] = id_homed_at(SLOT_MASK);
      for (int i = 0; i < 3; i++) send(OP_INSERT, wrap_id[i]);
      send(OP_LOOKUP, wrap_id[2]);
      send(OP_LOOKUP, wrap_id[3]);
      send(OP_CLEAR, $urandom);
      send(OP_LOOKUP, '1);

      write_limit('0);
      send(OP_INSERT, 32'h1234_5678);
      send(OP_LOOKUP, 32'h1234_5678);
      write_limit(ENTRY_BITS'(1));
      send(OP_INSERT, wrap_id[0]);
      send(OP_INSERT, '1);
      send(OP_INSERT, wrap_id[0]);
      write_limit('1);
      send(OP_INSERT, '1);
      send(OP_LOOKUP, 32'h0000_0001);

      run_phase(MAX_ENTRIES_RESET, 660, 1, 0);
      run_phase('1, 100, 0, 0);
      run_phase(ENTRY_BITS'(5), 120, 0, 1);
      run_phase(ENTRY_BITS'(1), 80, 0, 1);
      run_phase(ENTRY_BITS'(300), 190, 0, 1);

      wait_idle();
      repeat (40) @(posedge clock);
      if (shadow.failures == 0 && shadow.pending_replies.size() == 0) begin
         $display("hashed_id_index_linear_probe: match");
      end else begin
         $display("hashed_id_index_linear_probe: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/hidlp_pkg.sv
hw/rtl/hidlp_front.sv
hw/rtl/hidlp_queue.sv
hw/rtl/hidlp_back.sv
hw/rtl/hashed_id_index_linear_probe.sv
sim/hashed_id_index_linear_probe_tb.sv
